/* rtl/mms_pkg.sv */
`timescale 1ns / 1ps
// Package for the magic multiplier search core.
// Holds commands, config indexes, controller states and datapath command/status types.
package mms_pkg;

    localparam int TableIndexBits = 12;
    localparam int TableDepth     = 1 << TableIndexBits;
    localparam logic [26:0] TryLimitCap = 27'd100000000;
    localparam logic [31:0] SeedReset   = 32'd1804289383;
    localparam logic [3:0]  MinTopBits  = 4'd6;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_RESEED = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_MASK  = 2'd0,
        CFG_RBITS = 2'd1,
        CFG_TRIES = 2'd2,
        CFG_SEED  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OCC,
        ST_DRAW,
        ST_MUL,
        ST_CHECK,
        ST_CLEAR,
        ST_HASH,
        ST_DONE,
        ST_FAIL
    } t_state;

    typedef struct packed {
        logic start;
        logic occ_step;
        logic draw_step;
        logic mul_step;
        logic clear_step;
        logic hash_step;
        logic try_step;
        logic reseed;
        logic set_result;
        logic found;
    } t_dp_cmd;

    typedef struct packed {
        logic occ_last;
        logic draw_last;
        logic mul_last;
        logic top_ok;
        logic clear_last;
        logic hash_last;
        logic conflict;
        logic tries_out;
    } t_dp_sts;

endpackage

/* rtl/magic_multiplier_search_core.sv */
`timescale 1ns / 1ps
// Load, reseed and unused items are taken while idle and leave the core idle. A search
// item holds the input for its whole run: it builds the occupancy table, N being the
// clamped table index width, then per candidate draws generator words, multiplies
// and checks; passing candidates clear the slot table and hash up to 2^N entries,
// one entry a cycle through the read, multiply and slot compare pipeline until a conflict.
// The try limit ends a failing search. Result is held in an output register until taken.
module magic_multiplier_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_entry_index,
    input  logic [63:0] i_attack_set,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [63:0] o_magic,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import mms_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_busy;
    logic    r_out_v;
    logic    w_acc;

    assign o_ready     = !w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && o_ready;

    t_dp_cmd w_cmd_all;
    always_comb begin
        w_cmd_all = w_cmd;
        w_cmd_all.reseed = w_acc && (t_cmd'(i_command) == CMD_RESEED);
    end

    mms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_acc && (t_cmd'(i_command) == CMD_SEARCH)),
        .i_sts     (w_sts),
        .i_out_free(!r_out_v || i_ready),
        .o_cmd     (w_cmd),
        .o_busy    (w_busy)
    );

    mms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_load       (w_acc && (t_cmd'(i_command) == CMD_LOAD)),
        .i_entry_index(i_entry_index),
        .i_attack_set (i_attack_set),
        .i_cmd        (w_cmd_all),
        .o_sts        (w_sts),
        .o_found      (o_found),
        .o_magic      (o_magic)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)             r_out_v <= 1'b0;
        else if (w_cmd.set_result) r_out_v <= 1'b1;
        else if (i_ready)         r_out_v <= 1'b0;
    end
    assign o_valid = r_out_v;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_ready) else $error("item accepted while busy");
    a_result_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_magic == 64'd0)) else $error("fail with nonzero magic");
endmodule

/* rtl/mms_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the magic multiplier search core.
// Depends on mms_pkg; drives datapath commands from datapath status.
module mms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  mms_pkg::t_dp_sts  i_sts,
    input  logic              i_out_free,
    output mms_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import mms_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_OCC;
                end
            end
            ST_OCC: begin
                o_cmd.occ_step = 1'b1;
                if (i_sts.occ_last) n_state = ST_DRAW;
            end
            ST_DRAW: begin
                if (i_sts.tries_out) begin
                    n_state = ST_FAIL;
                end else begin
                    o_cmd.draw_step = 1'b1;
                    if (i_sts.draw_last) n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.try_step = 1'b1;
                n_state = i_sts.top_ok ? ST_CLEAR : ST_DRAW;
            end
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) n_state = ST_HASH;
            end
            ST_HASH: begin
                if (i_sts.conflict) begin
                    n_state = ST_DRAW;
                end else begin
                    o_cmd.hash_step = 1'b1;
                    if (i_sts.hash_last) n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.found = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FAIL: begin
                if (i_out_free) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.found = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

/* rtl/mms_dp.sv */
`timescale 1ns / 1ps
// Datapath for the magic multiplier search core: config, attack/slot/occupancy
// memories, xorshift generator, split multiplier and hash check. Depends on mms_pkg.
module mms_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_load,
    input  logic [11:0]       i_entry_index,
    input  logic [63:0]       i_attack_set,
    input  mms_pkg::t_dp_cmd  i_cmd,
    output mms_pkg::t_dp_sts  o_sts,
    output logic              o_found,
    output logic [63:0]       o_magic
);
    import mms_pkg::*;

    localparam int Ib = TableIndexBits;

    logic [63:0] r_mask;
    logic [3:0]  r_rbits;
    logic [26:0] r_tries;
    logic [31:0] r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_rbits <= 4'd12;
            r_tries <= TryLimitCap;
            r_seed  <= SeedReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MASK:  r_mask  <= i_cfg_data;
                CFG_RBITS: r_rbits <= i_cfg_data[3:0];
                CFG_TRIES: r_tries <= i_cfg_data[26:0];
                CFG_SEED:  r_seed  <= i_cfg_data[31:0];
                default:   r_mask  <= r_mask;
            endcase
        end
    end

    // clamp relevant bits
    logic [3:0] w_rb;
    always_comb begin
        if (r_rbits == 4'd0)                 w_rb = 4'd1;
        else if (r_rbits > 4'(Ib))           w_rb = 4'(Ib);
        else                                 w_rb = r_rbits;
    end
    logic [Ib:0] w_count;
    assign w_count = (Ib+1)'(1) << w_rb;

    // search latched settings
    logic [3:0]  r_rb;
    logic [26:0] r_limit;
    logic [26:0] r_tcnt;
    logic [Ib:0] r_cnt;

    // memories
    logic [63:0] m_attack [TableDepth];
    logic [63:0] m_occ    [TableDepth];
    logic [63:0] m_slot   [TableDepth];

    always_ff @(posedge i_clk) begin
        if (i_load) m_attack[i_entry_index] <= i_attack_set;
    end

    // occupancy: keep the lowest N set bits of the mask, then step through its
    // subsets in index order, one entry a cycle
    logic [63:0] r_omask;
    logic [63:0] r_emask;
    logic [63:0] r_occ;
    logic [Ib:0] r_ocnt;
    logic [3:0]  r_bit;
    logic [63:0] w_low;
    logic        w_obuild;
    assign w_low    = r_omask & (~r_omask + 64'd1);
    assign w_obuild = (r_bit != r_rb);

    // generator
    logic [31:0] r_rng;
    logic [31:0] w_x1, w_x2, w_x3;
    assign w_x1 = r_rng ^ (r_rng << 13);
    assign w_x2 = w_x1 ^ (w_x1 >> 17);
    assign w_x3 = w_x2 ^ (w_x2 << 5);

    logic [3:0]  r_dcnt;
    logic [63:0] r_word;
    logic [63:0] r_cand;

    // 64x64 low product built from 64x16 partials, one partial per cycle
    logic [1:0]  r_mcnt;
    logic [63:0] r_prod;
    logic [63:0] w_part;
    logic [15:0] w_cdig;
    assign w_cdig = r_cand[16*r_mcnt +: 16];
    assign w_part = (r_mask * {48'd0, w_cdig}) << (16 * r_mcnt);

    // hash pipeline: read occ/attack, four 64x16 multiply stages, read slot, compare
    logic [Ib:0] r_hcnt;
    logic [63:0] r_hocc, r_hatk;
    logic        r_hv0;
    logic [63:0] r_mocc [3];
    logic [63:0] r_macc [4];
    logic [63:0] r_matk [4];
    logic [3:0]  r_mv;
    logic [63:0] w_mocc [4];
    logic [63:0] w_mbase [4];
    logic [63:0] w_mp [4];
    logic [Ib-1:0] w_hs;
    logic [Ib-1:0] r_hs2;
    logic [63:0] r_hatk2, r_slot;
    logic        r_hv2;
    logic        r_conf;
    logic [Ib:0] r_ccnt;

    always_comb begin
        w_mocc[0]  = r_hocc;
        w_mbase[0] = '0;
        for (int k = 1; k < 4; k++) begin
            w_mocc[k]  = r_mocc[k-1];
            w_mbase[k] = r_macc[k-1];
        end
        for (int k = 0; k < 4; k++)
            w_mp[k] = (w_mocc[k] * {48'd0, r_cand[16*k +: 16]}) << (16 * k);
    end

    assign w_hs = Ib'((r_macc[3] >> (7'd64 - {3'd0, r_rb})) & ((64'd1 << r_rb) - 64'd1));

    // forwarding for back-to-back writes to the same slot
    logic [63:0] w_slot_cur;
    logic        r_wv;
    logic [Ib-1:0] r_ws;
    logic [63:0] r_wd;
    assign w_slot_cur = (r_wv && r_ws == r_hs2) ? r_wd : r_slot;

    logic w_write;
    assign w_write = r_hv2 && !r_conf && (w_slot_cur == 64'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rb    <= w_rb;
            r_limit <= (r_tries > TryLimitCap) ? TryLimitCap : r_tries;
            r_tcnt  <= '0;
            r_omask <= r_mask;
            r_emask <= '0;
            r_bit   <= '0;
            r_occ   <= '0;
            r_ocnt  <= '0;
            r_cnt   <= w_count;
        end
        if (i_cmd.occ_step) begin
            if (w_obuild) begin
                r_emask <= r_emask | w_low;
                r_omask <= r_omask & ~w_low;
                r_bit   <= r_bit + 1'b1;
            end else begin
                m_occ[r_ocnt[Ib-1:0]] <= r_occ;
                r_occ  <= (r_occ - r_emask) & r_emask;
                r_ocnt <= r_ocnt + 1'b1;
                if (r_ocnt == r_cnt - 1'b1) r_dcnt <= '0;
            end
        end
        if (i_cmd.draw_step) begin
            r_word[16*r_dcnt[1:0] +: 16] <= w_x3[15:0];
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt[1:0] == 2'd3) begin
                if (r_dcnt[3:2] == 2'd0) r_cand <= {w_x3[15:0], r_word[47:0]};
                else r_cand <= r_cand & {w_x3[15:0], r_word[47:0]};
            end
            r_mcnt <= '0;
            r_prod <= '0;
        end
        if (i_cmd.mul_step) begin
            r_prod <= r_prod + w_part;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.try_step) begin
            r_tcnt <= r_tcnt + 1'b1;
            r_dcnt <= '0;
            r_ccnt <= '0;
        end
        if (i_cmd.clear_step) begin
            m_slot[r_ccnt[Ib-1:0]] <= '0;
            r_ccnt <= r_ccnt + 1'b1;
            r_hcnt <= '0;
            r_conf <= 1'b0;
        end
        r_hv0 <= i_rst_n && i_cmd.hash_step && (r_hcnt < r_cnt);
        if (i_cmd.hash_step && r_hcnt < r_cnt) begin
            r_hocc <= m_occ[r_hcnt[Ib-1:0]];
            r_hatk <= m_attack[r_hcnt[Ib-1:0]];
            r_hcnt <= r_hcnt + 1'b1;
        end
        r_mv <= i_rst_n ? {r_mv[2:0], r_hv0} : 4'd0;
        for (int k = 0; k < 3; k++) r_mocc[k] <= w_mocc[k];
        for (int k = 0; k < 4; k++) r_macc[k] <= w_mbase[k] + w_mp[k];
        r_matk[0] <= r_hatk;
        for (int k = 1; k < 4; k++) r_matk[k] <= r_matk[k-1];
        r_hv2   <= i_rst_n && r_mv[3];
        r_hs2   <= w_hs;
        r_hatk2 <= r_matk[3];
        r_slot  <= m_slot[w_hs];
        r_wv    <= i_rst_n && w_write;
        r_ws    <= r_hs2;
        r_wd    <= r_hatk2;
        if (w_write) m_slot[r_hs2] <= r_hatk2;
        if (r_hv2 && w_slot_cur != 64'd0 && w_slot_cur != r_hatk2) r_conf <= 1'b1;
        if (!i_rst_n)                             r_rng <= SeedReset;
        else if (i_cmd.reseed)                    r_rng <= r_seed;
        else if (i_cmd.draw_step)                 r_rng <= w_x3;
        if (i_cmd.set_result) begin
            o_found <= i_cmd.found;
            o_magic <= i_cmd.found ? r_cand : 64'd0;
        end
    end

    logic [7:0] w_top;
    logic [3:0] w_pop;
    assign w_top = r_prod[63:56];
    always_comb begin
        w_pop = '0;
        for (int k = 0; k < 8; k++) w_pop = w_pop + {3'd0, w_top[k]};
    end

    always_comb begin
        o_sts = '0;
        o_sts.occ_last   = !w_obuild && (r_ocnt == r_cnt - 1'b1);
        o_sts.draw_last  = (r_dcnt == 4'd11);
        o_sts.mul_last   = (r_mcnt == 2'd3);
        o_sts.top_ok     = (w_pop >= MinTopBits);
        o_sts.clear_last = (r_ccnt == r_cnt - 1'b1);
        o_sts.hash_last  = (r_hcnt == r_cnt) && !r_hv0 && (r_mv == 4'd0) && !r_hv2;
        o_sts.conflict   = r_conf;
        o_sts.tries_out  = (r_tcnt >= r_limit) && (r_dcnt == 4'd0);
    end
endmodule
